@@ hdl/rfa_pkg.sv @@
// Package for the four-fraction rational ALU: operation codes, item kinds,
// sequencer states and the queue status bundle. No dependencies.
`default_nettype none

package rfa_pkg;

    localparam int IN_FIELD_W = 12;
    localparam int OUT_W      = 48;
    localparam int N_OPND     = 8;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    typedef enum logic [2:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_BAD
    } kind_t;

    localparam int KIND_W = $bits(kind_t);

    typedef enum logic [1:0] {
        U_T,
        U_B,
        U_N,
        U_D
    } uop_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_COMB,
        S_CHECK,
        S_GSH,
        S_GA,
        S_GLOOP,
        S_GSCALE,
        S_DIVLD,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

@@ hdl/rfa_front.sv @@
// Front end: accepts input transfers, decodes the operation into an item kind
// and trims or zero-pads each operand to OPERAND_BITS bits for the queue. Uses rfa_pkg.
`default_nettype none

module rfa_front import rfa_pkg::*; #(
    parameter int OPERAND_BITS = 12,
    parameter int ENTRY_W      = KIND_W + N_OPND * OPERAND_BITS
) (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [103:0]          s_tdata,
    input  wire q_stat_t               q_stat,
    output logic                       push,
    output logic [ENTRY_W-1:0]         push_data
);

    localparam int PADW = (OPERAND_BITS > IN_FIELD_W) ? OPERAND_BITS : IN_FIELD_W;

    kind_t kind;
    logic [2:0] op;
    logic [N_OPND*OPERAND_BITS-1:0] opnds;

    assign op       = s_tdata[2:0];
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        unique case (op)
            OP_ADD:  kind = KIND_ADD;
            OP_SUB:  kind = KIND_SUB;
            OP_MUL:  kind = KIND_MUL;
            OP_DIV:  kind = KIND_DIV;
            default: kind = KIND_BAD;
        endcase
    end

    for (genvar i = 0; i < N_OPND; i++) begin : g_opnd
        logic [PADW-1:0] padded;
        assign padded = PADW'(s_tdata[3 + i*IN_FIELD_W +: IN_FIELD_W]);
        assign opnds[i*OPERAND_BITS +: OPERAND_BITS] = padded[OPERAND_BITS-1:0];
    end

    assign push_data = {opnds, kind};

endmodule

`default_nettype wire

@@ hdl/rfa_queue.sv @@
// Two-entry queue between the front end and the arithmetic back end.
// Uses rfa_pkg for the status bundle.
`default_nettype none

module rfa_queue import rfa_pkg::*; #(
    parameter int WIDTH = 99
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output q_stat_t               q_stat
);

    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic do_pop;

    assign do_pop       = pop && (count_reg != 2'd0);
    assign pop_data     = mem_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rfa_back.sv @@
// Back end: shift-add multiplier sequence, binary gcd and restoring divider,
// with the result register toward the output channel. Uses rfa_pkg.
`default_nettype none

module rfa_back import rfa_pkg::*; #(
    parameter int OPERAND_BITS = 12,
    parameter int ENTRY_W      = KIND_W + N_OPND * OPERAND_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire q_stat_t            q_stat,
    input  wire logic [ENTRY_W-1:0] pop_data,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [95:0]             m_tdata
);

    localparam int B   = OPERAND_BITS;
    localparam int W   = 4 * B;
    localparam int CW  = $clog2(W + 1);
    localparam int MC  = $clog2(B);
    localparam int EXW = (W > OUT_W) ? W : OUT_W;

    state_t state_reg, state_next;
    uop_t   uop_reg, uop_next;
    kind_t  kind_reg, kind_next;
    logic [1:0] idx_reg, idx_next;
    logic signed [B-1:0] opnd_reg [N_OPND];
    logic load_opnd;
    logic signed [W-1:0] rn_reg, rn_next, rd_reg, rd_next, ta_reg, ta_next;
    logic signed [W-1:0] acc_reg, acc_next, mx_reg, mx_next;
    logic [B-1:0] my_reg, my_next;
    logic [MC-1:0] mcnt_reg, mcnt_next;
    logic [W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [CW-1:0] sh_reg, sh_next, dcnt_reg, dcnt_next;
    logic [W-1:0] dvd_reg, dvd_next, rem_reg, rem_next;
    logic dsel_reg, dsel_next;
    logic signed [W-1:0] res_n_reg, res_n_next, res_d_reg, res_d_next;
    logic out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_n_reg, out_n_next, out_d_reg, out_d_next;

    logic mul_last, den_sel, is_addsub, gloop_done, div_last, out_free;
    logic [2:0] sel_addr;
    logic signed [W-1:0] prod, term, comb_sum, quot_s;
    logic [W-1:0] abs_n, abs_d, rem_sh, quot;
    logic rem_ge;
    logic signed [EXW-1:0] ext_n, ext_d;

    assign is_addsub  = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
    assign mul_last   = (mcnt_reg == MC'(B - 1));
    assign div_last   = (dcnt_reg == CW'(W - 1));
    assign gloop_done = (gb_reg == '0);
    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = (state_reg == S_IDLE) && q_stat.valid;
    assign load_opnd  = pop;

    assign abs_n = rn_reg[W-1] ? W'(-rn_reg) : W'(rn_reg);
    assign abs_d = rd_reg[W-1] ? W'(-rd_reg) : W'(rd_reg);

    always_comb begin
        case (uop_reg)
            U_T:     den_sel = 1'b1;
            U_B:     den_sel = 1'b0;
            U_N:     den_sel = (kind_reg == KIND_DIV);
            default: den_sel = (kind_reg != KIND_DIV);
        endcase
    end
    assign sel_addr = {idx_reg, den_sel};

    assign term     = mul_last ? -mx_reg : mx_reg;
    assign prod     = my_reg[0] ? acc_reg + term : acc_reg;
    assign comb_sum = (kind_reg == KIND_SUB) ? ta_reg - acc_reg : ta_reg + acc_reg;

    assign rem_sh = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign rem_ge = (rem_sh >= ga_reg);
    assign quot   = {dvd_reg[W-2:0], rem_ge};
    assign quot_s = (dsel_reg ? rd_reg[W-1] : rn_reg[W-1]) ? -$signed(quot) : $signed(quot);

    assign ext_n = EXW'(res_n_reg);
    assign ext_d = EXW'(res_d_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_stat.valid) begin
                    state_next = (kind_t'(pop_data[KIND_W-1:0]) == KIND_BAD) ? S_CHECK
                                                                               : S_SETUP;
                end
            end
            S_SETUP: state_next = S_MUL;
            S_MUL: begin
                if (mul_last) begin
                    if (uop_reg == U_B) begin
                        state_next = S_COMB;
                    end else if (uop_reg == U_D && idx_reg == 2'd3) begin
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_COMB: state_next = S_SETUP;
            S_CHECK: begin
                if (rd_reg == '0 || rn_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_GSH;
                end
            end
            S_GSH: begin
                if (ga_reg[0] || gb_reg[0]) begin
                    state_next = S_GA;
                end
            end
            S_GA: begin
                if (ga_reg[0]) begin
                    state_next = S_GLOOP;
                end
            end
            S_GLOOP: begin
                if (gloop_done) begin
                    state_next = S_GSCALE;
                end
            end
            S_GSCALE: state_next = S_DIVLD;
            S_DIVLD:  state_next = S_DIV;
            S_DIV: begin
                if (div_last) begin
                    state_next = dsel_reg ? S_DONE : S_DIVLD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        uop_next       = uop_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        ta_next        = ta_reg;
        acc_next       = acc_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mcnt_next      = mcnt_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        sh_next        = sh_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        dsel_next      = dsel_reg;
        res_n_next     = res_n_reg;
        res_d_next     = res_d_reg;
        out_n_next     = out_n_reg;
        out_d_next     = out_d_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (q_stat.valid) begin
                    kind_next = kind_t'(pop_data[KIND_W-1:0]);
                    idx_next  = 2'd1;
                    rn_next   = W'($signed(pop_data[KIND_W +: B]));
                    rd_next   = W'($signed(pop_data[KIND_W + B +: B]));
                    case (kind_t'(pop_data[KIND_W-1:0]))
                        KIND_ADD, KIND_SUB: uop_next = U_T;
                        KIND_MUL, KIND_DIV: uop_next = U_N;
                        default: begin
                            uop_next = U_N;
                            rd_next  = '0;
                        end
                    endcase
                end
            end
            S_SETUP: begin
                mx_next   = (uop_reg == U_T || uop_reg == U_N) ? rn_reg : rd_reg;
                my_next   = opnd_reg[sel_addr];
                acc_next  = '0;
                mcnt_next = '0;
            end
            S_MUL: begin
                acc_next  = prod;
                mx_next   = mx_reg <<< 1;
                my_next   = my_reg >> 1;
                mcnt_next = mcnt_reg + MC'(1);
                if (mul_last) begin
                    case (uop_reg)
                        U_T: begin
                            ta_next  = prod;
                            uop_next = U_B;
                        end
                        U_B: uop_next = U_D;
                        U_N: begin
                            rn_next  = prod;
                            uop_next = U_D;
                        end
                        default: begin
                            rd_next  = prod;
                            idx_next = idx_reg + 2'd1;
                            uop_next = is_addsub ? U_T : U_N;
                        end
                    endcase
                end
            end
            S_COMB: rn_next = comb_sum;
            S_CHECK: begin
                if (rd_reg == '0) begin
                    res_n_next = '0;
                    res_d_next = '0;
                end else if (rn_reg == '0) begin
                    res_n_next = '0;
                    res_d_next = rd_reg;
                end
                ga_next = abs_n;
                gb_next = abs_d;
                sh_next = '0;
            end
            S_GSH: begin
                if (!(ga_reg[0] || gb_reg[0])) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    sh_next = sh_reg + CW'(1);
                end
            end
            S_GA: begin
                if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end
            end
            S_GLOOP: begin
                if (!gloop_done) begin
                    if (!gb_reg[0]) begin
                        gb_next = gb_reg >> 1;
                    end else if (ga_reg > gb_reg) begin
                        ga_next = gb_reg;
                        gb_next = ga_reg - gb_reg;
                    end else begin
                        gb_next = gb_reg - ga_reg;
                    end
                end
            end
            S_GSCALE: begin
                ga_next   = ga_reg << sh_reg;
                dsel_next = 1'b0;
            end
            S_DIVLD: begin
                dvd_next  = dsel_reg ? abs_d : abs_n;
                rem_next  = '0;
                dcnt_next = '0;
            end
            S_DIV: begin
                rem_next  = rem_ge ? rem_sh - ga_reg : rem_sh;
                dvd_next  = quot;
                dcnt_next = dcnt_reg + CW'(1);
                if (div_last) begin
                    if (dsel_reg) begin
                        res_d_next = quot_s;
                    end else begin
                        res_n_next = quot_s;
                    end
                    dsel_next = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_n_next     = ext_n[OUT_W-1:0];
                    out_d_next     = ext_d[OUT_W-1:0];
                    out_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        uop_reg   <= uop_next;
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        ta_reg    <= ta_next;
        acc_reg   <= acc_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        mcnt_reg  <= mcnt_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        sh_reg    <= sh_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        dsel_reg  <= dsel_next;
        res_n_reg <= res_n_next;
        res_d_reg <= res_d_next;
        out_n_reg <= out_n_next;
        out_d_reg <= out_d_next;
        if (load_opnd) begin
            for (int i = 0; i < N_OPND; i++) begin
                opnd_reg[i] <= pop_data[KIND_W + i*B +: B];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_d_reg, out_n_reg};

endmodule

`default_nettype wire

@@ hdl/four_fraction_rational_alu_core.sv @@
// Top level of the four-fraction rational ALU: front end, two-entry queue
// and arithmetic back end. Uses rfa_pkg, rfa_front, rfa_queue and rfa_back.
//
// Channel  Dir  Ports                       Payload
// s_       in   s_tvalid s_tready s_tdata   operation, four numerator/denominator pairs
// m_       out  m_tvalid m_tready m_tdata   result_num, result_den
//
// Each item runs alone in the back end: a load step, then shift-add multiplies (nine for
// add and subtract plus three combine steps, six for multiply and divide), then the binary
// gcd on 4*OPERAND_BITS wide magnitudes, and two restoring divisions by the gcd.
// Zero numerators, zero denominators and invalid operations skip gcd and division.
// The queue holds two items, so the input keeps taking transfers while a result waits, until the queue is full.
// Reset is synchronous and active low and empties the queue and the output register.
`default_nettype none

module four_fraction_rational_alu_core import rfa_pkg::*; #(
    parameter int OPERAND_BITS = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // operation, first_num, first_den, second_num, second_den, third_num,
    // third_den, fourth_num, fourth_den, zero fill
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_num, result_den
    output logic [95:0]       m_tdata
);

    localparam int ENTRY_W = KIND_W + N_OPND * OPERAND_BITS;

    q_stat_t q_stat;
    logic push, pop;
    logic [ENTRY_W-1:0] push_data, pop_data;

    rfa_front #(
        .OPERAND_BITS (OPERAND_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    rfa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rfa_back #(
        .OPERAND_BITS (OPERAND_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    a_zero_den_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[95:48] == '0) |-> (m_tdata[47:0] == '0))
        else $error("result with zero denominator has a nonzero numerator");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_stat.valid)
        else $error("accepted transfer did not reach the queue");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for four_fraction_rational_alu_core: directed and random items checked
// against an in-bench rational predictor with gcd reduction. Depends on rfa_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top import rfa_pkg::*;;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [103:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;

    typedef struct packed {
        logic signed [47:0] den;
        logic signed [47:0] num;
    } ratio_t;

    ratio_t reduced_q[$];
    int n_err = 0;
    int n_sent = 0;
    int n_got = 0;
    int burst_left = 0;
    logic [3:0] stall_pat = 4'b0;

    always #10 aclk = ~aclk;

    four_fraction_rational_alu_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] bin_gcd(logic [63:0] a, logic [63:0] b);
        int sh;
        logic [63:0] t;
        sh = 0;
        while (((a | b) & 1) == 0) begin
            a = a >> 1;
            b = b >> 1;
            sh++;
        end
        while (a[0] == 1'b0) a = a >> 1;
        while (b != 0) begin
            while (b[0] == 1'b0) b = b >> 1;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end
        return a << sh;
    endfunction

    function automatic ratio_t chain_fractions(logic [103:0] d);
        longint n[4];
        longint q[4];
        longint rn, rd, g;
        logic [2:0] op;
        ratio_t r;
        op = d[2:0];
        for (int i = 0; i < 4; i++) begin
            n[i] = longint'($signed(d[3 + 24 * i +: 12]));
            q[i] = longint'($signed(d[15 + 24 * i +: 12]));
        end
        rn = 0;
        rd = 0;
        if (op == OP_ADD || op == OP_SUB) begin
            rn = n[0];
            rd = q[0];
            for (int i = 1; i < 4; i++) begin
                rn = (op == OP_ADD) ? rn * q[i] + n[i] * rd : rn * q[i] - n[i] * rd;
                rd = rd * q[i];
            end
        end else if (op == OP_MUL) begin
            rn = n[0] * n[1] * n[2] * n[3];
            rd = q[0] * q[1] * q[2] * q[3];
        end else if (op == OP_DIV) begin
            rn = n[0] * q[1] * q[2] * q[3];
            rd = q[0] * n[1] * n[2] * n[3];
        end
        if (rd == 0) begin
            rn = 0;
        end else if (rn != 0) begin
            g = longint'(bin_gcd(mag64(rn), mag64(rd)));
            rn = rn / g;
            rd = rd / g;
        end
        r.num = rn[47:0];
        r.den = rd[47:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        n_err++;
    endtask

    task automatic send_item(logic [2:0] op, logic [11:0] f[8]);
        logic [103:0] d;
        int gap;
        d = '0;
        d[2:0] = op;
        for (int i = 0; i < 8; i++) d[3 + 12 * i +: 12] = f[i];
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= d;
        reduced_q.push_back(chain_fractions(d));
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ratio_t w;
            n_got++;
            if (reduced_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[47:0], '0);
            end else begin
                w = reduced_q.pop_front();
                if (m_tdata[47:0] !== w.num) report_mismatch("result_num", m_tdata[47:0], w.num);
                if (m_tdata[95:48] !== w.den) report_mismatch("result_den", m_tdata[95:48], w.den);
            end
        end
        if ($urandom_range(0, 63) == 0) stall_pat <= 4'($urandom);
        m_tready <= (stall_pat == 4'hF) ? 1'b1 : ($urandom_range(0, 3) != 0 || stall_pat[0]);
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reduced_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        logic [11:0] f[8];
        logic [11:0] vals[6] = '{12'h800, 12'h7FF, 12'h001, 12'hFFF, 12'h000, 12'h555};
        for (int k = 0; k < 6; k++) begin
            foreach (f[i]) f[i] = vals[k];
            send_item(OP_MUL, f);
            send_item(OP_DIV, f);
        end
    endtask

    task automatic test_operations();
        logic [11:0] f[8];
        for (int op = 0; op < 8; op++) begin
            foreach (f[i]) f[i] = 12'($urandom_range(1, 40));
            f[1] = 12'hFFD;
            send_item(3'(op), f);
        end
        foreach (f[i]) f[i] = 12'd3;
        f[3] = 12'd0;
        send_item(OP_ADD, f);
        f[3] = 12'd3;
        f[2] = 12'd0;
        send_item(OP_DIV, f);
        foreach (f[i]) f[i] = 12'd5;
        send_item(OP_SUB, f);
    endtask

    task automatic test_random();
        logic [11:0] f[8];
        logic [2:0] op;
        for (int k = 0; k < 930; k++) begin
            op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
            foreach (f[i]) begin
                case ($urandom_range(0, 5))
                    0: f[i] = 12'($urandom);
                    1: f[i] = 12'($urandom_range(0, 2));
                    default: f[i] = 12'($signed($urandom_range(0, 64)) - 32);
                endcase
            end
            send_item(op, f);
            if (k == 400) wait_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_operations();
        wait_drained();
        test_random();
        wait_drained();
        repeat (400) @(posedge aclk);
        $display("Sent %0d items covering all operation codes, extreme operands and zero cases;",
                 n_sent);
        $display("checked %0d results with random input gaps and output stalls.", n_got);
        if (n_err == 0 && reduced_q.size() == 0) begin
            $display("four_fraction_rational_alu_core regression: pass");
        end else begin
            $display("four_fraction_rational_alu_core regression: fail");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("four_fraction_rational_alu_core regression: fail");
        $finish;
    end
endmodule
